FILE: design/ets_pkg.sv
// shared types and constants for the expression token scanner
package ets_pkg;

    typedef enum logic [1:0] {
        SM_IDLE   = 2'd0,
        SM_NUMBER = 2'd1,
        SM_NAME   = 2'd2
    } scan_mode_t;

    typedef enum logic [3:0] {
        TK_UNKNOWN  = 4'd0,
        TK_NUMBER   = 4'd1,
        TK_VARIABLE = 4'd2,
        TK_FUNCTION = 4'd3,
        TK_LPAREN   = 4'd4,
        TK_RPAREN   = 4'd5,
        TK_COMMA    = 4'd6,
        TK_OPERATOR = 4'd7,
        TK_END      = 4'd8
    } token_kind_t;

    typedef enum logic [2:0] {
        OP_PLUS   = 3'd0,
        OP_MINUS  = 3'd1,
        OP_TIMES  = 3'd2,
        OP_DIVIDE = 3'd3,
        OP_POWER  = 3'd4
    } op_code_t;

    localparam logic [1:0] PREC_NONE = 2'd0;
    localparam logic [1:0] PREC_ADD  = 2'd1;
    localparam logic [1:0] PREC_MUL  = 2'd2;
    localparam logic [1:0] PREC_POW  = 2'd3;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_DIVIDE = 8'h2F;
    localparam logic [7:0] CH_POWER  = 8'h5E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    localparam int KW_COUNT = 10;

    // sin cos tg ctg asin acos atan actg log sqrt, first letter highest
    localparam logic [31:0] KW_BITS [KW_COUNT] = '{
        32'h0073696E, 32'h00636F73, 32'h00007467, 32'h00637467, 32'h6173696E,
        32'h61636F73, 32'h6174616E, 32'h61637467, 32'h006C6F67, 32'h73717274
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd4
    };

endpackage

FILE: design/expression_token_scanner_core.sv
// expression token scanner: character in, up to two tokens out per character
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid, in_stall | char_code, last_char
//  out     | out_valid,out_stall| token_kind, precedence, function_id,
//          |                    | operator_code, token_start, token_length,
//          |                    | last_of_run, end_of_expression
//
// One character is classified and its tokens written to the result queue in
// the cycle it is taken, so a character can be taken every cycle while in_stall is low.
// The three-entry result queue drains one token a cycle while out_stall is low;
// a request is taken while it holds at most one token, and a character giving
// two tokens hands them to the output one at a time.
// Reset clears scanner state and empties the queue; positions restart at zero.
module expression_token_scanner_core #(
    parameter int POSITION_WIDTH = 16,
    parameter int NAME_KEEP      = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                char_code,
    input  logic                      last_char,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [3:0]                token_kind,
    output logic [1:0]                precedence,
    output logic [3:0]                function_id,
    output logic [2:0]                operator_code,
    output logic [POSITION_WIDTH-1:0] token_start,
    output logic [POSITION_WIDTH-1:0] token_length,
    output logic                      last_of_run,
    output logic                      end_of_expression
);
    import ets_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int LW = 8 * NAME_KEEP;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    typedef struct packed {
        token_kind_t   kind;
        logic [1:0]    prec;
        logic [3:0]    fid;
        logic [2:0]    op;
        logic [PW-1:0] start;
        logic [PW-1:0] len;
        logic          run_last;
        logic          expr_end;
    } token_t;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
        return (v == POS_MAX) ? v : v + PW'(1);
    endfunction

    // keyword match: {hit, id}
    function automatic logic [4:0] kw_lookup(input logic [LW-1:0] letters,
                                             input logic [PW-1:0] len);
        logic       hit;
        logic [3:0] id;
        hit = 1'b0;
        id  = 4'd0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!hit && len == PW'(KW_LEN[i]) && letters == LW'(KW_BITS[i])) begin
                hit = 1'b1;
                id  = 4'(i);
            end
        end
        return {hit, id};
    endfunction

    function automatic token_t name_or_number(input scan_mode_t mode,
                                              input logic [LW-1:0] letters,
                                              input logic too_long,
                                              input logic [PW-1:0] start,
                                              input logic [PW-1:0] len);
        token_t     t;
        logic [4:0] kw;
        t       = '0;
        kw      = kw_lookup(letters, len);
        t.start = start;
        t.len   = len;
        if (mode == SM_NUMBER) begin
            t.kind = TK_NUMBER;
        end
        else if (kw[4] && !too_long) begin
            t.kind = TK_FUNCTION;
            t.fid  = kw[3:0];
        end
        else begin
            t.kind = TK_VARIABLE;
        end
        return t;
    endfunction

    // scanner state
    scan_mode_t    mode_reg, mode_next;
    logic          dot_seen_reg, dot_seen_next;
    logic [PW-1:0] pend_start_reg, pend_start_next;
    logic [PW-1:0] pend_len_reg, pend_len_next;
    logic [LW-1:0] letters_reg, letters_next;
    logic          too_long_reg, too_long_next;
    logic [PW-1:0] pos_reg, pos_next;

    // result queue, head at slot 0
    token_t        slot_reg [3];
    token_t        slot_next [3];
    logic [1:0]    count_reg, count_next;

    logic          accept, pop;
    logic          is_digit, is_dot, is_alpha, is_space;
    logic          cont_num, cont_name, cont;

    // pending token after this character
    scan_mode_t    mode_upd;
    logic [PW-1:0] start_upd, len_upd;
    logic [LW-1:0] letters_upd;
    logic          too_long_upd;

    token_t        tok_old, tok_new, tok_a, tok_b;
    logic          have_old, have_new;
    logic [1:0]    n_tok;
    logic [1:0]    base;

    assign in_stall  = (count_reg > 2'd1);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_dot   = (char_code == CH_DOT);
        is_alpha = ((char_code >= CH_UP_A) && (char_code <= CH_UP_Z))
                || ((char_code >= CH_LO_A) && (char_code <= CH_LO_Z));
        is_space = (char_code == CH_SPACE)
                || ((char_code >= CH_TAB) && (char_code <= CH_CR));
        cont_num  = (mode_reg == SM_NUMBER) && (is_digit || (is_dot && !dot_seen_reg));
        cont_name = (mode_reg == SM_NAME) && is_alpha;
        cont      = cont_num || cont_name;
    end

    // next scanner state
    always_comb
    begin
        mode_upd     = mode_reg;
        start_upd    = pend_start_reg;
        len_upd      = pend_len_reg;
        letters_upd  = letters_reg;
        too_long_upd = too_long_reg;
        dot_seen_next = dot_seen_reg;
        if (cont) begin
            len_upd = sat_inc(pend_len_reg);
            if (cont_num) begin
                dot_seen_next = dot_seen_reg || is_dot;
            end
            else if (pend_len_reg < PW'(NAME_KEEP)) begin
                letters_upd = {letters_reg[LW-9:0], char_code};
            end
            else begin
                too_long_upd = 1'b1;
            end
        end
        else if (is_digit || is_dot) begin
            mode_upd      = SM_NUMBER;
            dot_seen_next = is_dot;
            start_upd     = pos_reg;
            len_upd       = PW'(1);
        end
        else if (is_alpha) begin
            mode_upd      = SM_NAME;
            dot_seen_next = 1'b0;
            letters_upd   = LW'(char_code);
            too_long_upd  = 1'b0;
            start_upd     = pos_reg;
            len_upd       = PW'(1);
        end
        else begin
            mode_upd      = SM_IDLE;
            dot_seen_next = 1'b0;
        end

        if (last_char) begin
            mode_next       = SM_IDLE;
            dot_seen_next   = 1'b0;
            pend_start_next = '0;
            pend_len_next   = '0;
            letters_next    = '0;
            too_long_next   = 1'b0;
            pos_next        = '0;
        end
        else begin
            mode_next       = mode_upd;
            pend_start_next = start_upd;
            pend_len_next   = len_upd;
            letters_next    = letters_upd;
            too_long_next   = too_long_upd;
            pos_next        = sat_inc(pos_reg);
        end
    end

    // tokens caused by this character
    always_comb
    begin
        tok_old  = name_or_number(mode_reg, letters_reg, too_long_reg,
                                  pend_start_reg, pend_len_reg);
        have_old = !cont && (mode_reg != SM_IDLE);

        tok_new       = '0;
        tok_new.start = pos_reg;
        tok_new.len   = PW'(1);
        have_new      = 1'b0;
        if (!cont && !is_digit && !is_dot && !is_alpha && !is_space) begin
            have_new = 1'b1;
            case (char_code)
                CH_LPAREN: tok_new.kind = TK_LPAREN;
                CH_RPAREN: tok_new.kind = TK_RPAREN;
                CH_COMMA:  tok_new.kind = TK_COMMA;
                CH_PLUS:
                begin
                    tok_new.kind = TK_OPERATOR;
                    tok_new.prec = PREC_ADD;
                    tok_new.op   = OP_PLUS;
                end
                CH_MINUS:
                begin
                    tok_new.kind = TK_OPERATOR;
                    tok_new.prec = PREC_ADD;
                    tok_new.op   = OP_MINUS;
                end
                CH_TIMES:
                begin
                    tok_new.kind = TK_OPERATOR;
                    tok_new.prec = PREC_MUL;
                    tok_new.op   = OP_TIMES;
                end
                CH_DIVIDE:
                begin
                    tok_new.kind = TK_OPERATOR;
                    tok_new.prec = PREC_MUL;
                    tok_new.op   = OP_DIVIDE;
                end
                CH_POWER:
                begin
                    tok_new.kind = TK_OPERATOR;
                    tok_new.prec = PREC_POW;
                    tok_new.op   = OP_POWER;
                end
                default:   tok_new.kind = TK_UNKNOWN;
            endcase
        end
        else if (last_char && mode_upd != SM_IDLE) begin
            // final character flushes whatever is pending
            have_new = 1'b1;
            tok_new  = name_or_number(mode_upd, letters_upd, too_long_upd,
                                      start_upd, len_upd);
        end
        else if (last_char && !have_old) begin
            have_new     = 1'b1;
            tok_new.kind = TK_END;
            tok_new.len  = '0;
        end

        n_tok = {1'b0, have_old} + {1'b0, have_new};
        tok_a = have_old ? tok_old : tok_new;
        tok_b = tok_new;
        if (n_tok == 2'd2) begin
            tok_b.run_last = 1'b1;
            tok_b.expr_end = last_char;
        end
        else begin
            tok_a.run_last = 1'b1;
            tok_a.expr_end = last_char;
        end
    end

    // queue update: shift on pop, append new tokens behind what remains
    always_comb
    begin
        base = count_reg - {1'b0, pop};
        for (int i = 0; i < 2; i++) begin
            slot_next[i] = pop ? slot_reg[i+1] : slot_reg[i];
        end
        slot_next[2] = slot_reg[2];
        for (int i = 0; i < 3; i++) begin
            if (accept && n_tok != 2'd0 && 2'(i) == base) begin
                slot_next[i] = tok_a;
            end
            if (accept && n_tok == 2'd2 && 2'(i) == base + 2'd1) begin
                slot_next[i] = tok_b;
            end
        end
        count_next = base + (accept ? n_tok : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= SM_IDLE;
            dot_seen_reg <= 1'b0;
            too_long_reg <= 1'b0;
            pos_reg      <= '0;
            pend_start_reg <= '0;
            pend_len_reg <= '0;
            letters_reg  <= '0;
            count_reg    <= 2'd0;
        end
        else begin
            if (accept) begin
                mode_reg       <= mode_next;
                dot_seen_reg   <= dot_seen_next;
                too_long_reg   <= too_long_next;
                pos_reg        <= pos_next;
                pend_start_reg <= pend_start_next;
                pend_len_reg   <= pend_len_next;
                letters_reg    <= letters_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign token_kind        = slot_reg[0].kind;
    assign precedence        = slot_reg[0].prec;
    assign function_id       = slot_reg[0].fid;
    assign operator_code     = slot_reg[0].op;
    assign token_start       = slot_reg[0].start;
    assign token_length      = slot_reg[0].len;
    assign last_of_run       = slot_reg[0].run_last;
    assign end_of_expression = slot_reg[0].expr_end;

endmodule

FILE: test/ets_token_checker.sv
// token checker for the expression token scanner: predicts tokens per character and compares
module ets_token_checker #(
    parameter int POSITION_WIDTH = 16,
    parameter int NAME_KEEP      = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [7:0]                char_code,
    input  logic                      last_char,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [3:0]                token_kind,
    input  logic [1:0]                precedence,
    input  logic [3:0]                function_id,
    input  logic [2:0]                operator_code,
    input  logic [POSITION_WIDTH-1:0] token_start,
    input  logic [POSITION_WIDTH-1:0] token_length,
    input  logic                      last_of_run,
    input  logic                      end_of_expression,
    output int                        fail_count,
    output int                        open_tokens,
    output int                        tokens_checked,
    output logic [8:0]                kinds_seen
);
    import ets_pkg::*;

    typedef struct packed {
        token_kind_t               kind;
        logic [1:0]                prec;
        logic [3:0]                fid;
        op_code_t                  op;
        logic [POSITION_WIDTH-1:0] start;
        logic [POSITION_WIDTH-1:0] size;
        logic                      lor;
        logic                      eoe;
    } token_t;

    token_t expected_tokens[$];
    token_t step_tok [2];
    int     step_count;

    // scanner state as predicted
    scan_mode_t                mode;
    logic                      dot_seen;
    logic [POSITION_WIDTH-1:0] pend_start;
    logic [POSITION_WIDTH-1:0] pend_len;
    logic [8*NAME_KEEP-1:0]    letters;
    logic                      name_long;
    logic [POSITION_WIDTH-1:0] char_pos;

    function automatic logic [POSITION_WIDTH-1:0] sat_inc(input logic [POSITION_WIDTH-1:0] v);
        return (&v) ? v : v + POSITION_WIDTH'(1);
    endfunction

    // letters kept first-highest, so a short name compares against the plain literal
    function automatic int keyword_index(input logic [63:0] text);
        case (text)
            "sin":   return 0;
            "cos":   return 1;
            "tg":    return 2;
            "ctg":   return 3;
            "asin":  return 4;
            "acos":  return 5;
            "atan":  return 6;
            "actg":  return 7;
            "log":   return 8;
            "sqrt":  return 9;
            default: return -1;
        endcase
    endfunction

    task automatic clear_scan();
        mode       = SM_IDLE;
        dot_seen   = 1'b0;
        pend_start = '0;
        pend_len   = '0;
        letters    = '0;
        name_long  = 1'b0;
        char_pos   = '0;
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic add_token(input token_kind_t kind, input logic [1:0] prec,
                             input logic [3:0] fid, input op_code_t op,
                             input logic [POSITION_WIDTH-1:0] start,
                             input logic [POSITION_WIDTH-1:0] size);
        step_tok[step_count] = '{kind, prec, fid, op, start, size, 1'b0, 1'b0};
        step_count++;
    endtask

    task automatic close_pending();
        token_kind_t kind;
        int          idx;
        if (mode == SM_NUMBER)
            add_token(TK_NUMBER, PREC_NONE, 4'd0, OP_PLUS, pend_start, pend_len);
        else if (mode == SM_NAME) begin
            kind = TK_VARIABLE;
            idx  = name_long ? -1 : keyword_index(64'(letters));
            if (idx >= 0)
                kind = TK_FUNCTION;
            add_token(kind, PREC_NONE, (idx >= 0) ? 4'(idx) : 4'd0, OP_PLUS,
                      pend_start, pend_len);
        end
        mode     = SM_IDLE;
        dot_seen = 1'b0;
    endtask

    task automatic scan_char(input logic [7:0] c, input logic is_last);
        logic [POSITION_WIDTH-1:0] pos;
        logic                      is_digit, is_dot, is_alpha, is_space;
        token_kind_t               kind;
        logic [1:0]                prec;
        op_code_t                  op;
        pos        = char_pos;
        is_digit   = c >= CH_ZERO && c <= CH_NINE;
        is_dot     = c == CH_DOT;
        is_alpha   = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        is_space   = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        step_count = 0;
        if (mode == SM_NUMBER && (is_digit || (is_dot && !dot_seen))) begin
            if (is_dot)
                dot_seen = 1'b1;
            pend_len = sat_inc(pend_len);
        end
        else if (mode == SM_NAME && is_alpha) begin
            if (pend_len < POSITION_WIDTH'(NAME_KEEP))
                letters = {letters[8*NAME_KEEP-9:0], c};
            else
                name_long = 1'b1;
            pend_len = sat_inc(pend_len);
        end
        else begin
            close_pending();
            if (is_digit || is_dot) begin
                mode       = SM_NUMBER;
                dot_seen   = is_dot;
                pend_start = pos;
                pend_len   = POSITION_WIDTH'(1);
            end
            else if (is_alpha) begin
                mode       = SM_NAME;
                letters    = '0;
                letters[7:0] = c;
                name_long  = 1'b0;
                pend_start = pos;
                pend_len   = POSITION_WIDTH'(1);
            end
            else if (!is_space) begin
                kind = TK_UNKNOWN;
                prec = PREC_NONE;
                op   = OP_PLUS;
                case (c)
                    CH_LPAREN: kind = TK_LPAREN;
                    CH_RPAREN: kind = TK_RPAREN;
                    CH_COMMA:  kind = TK_COMMA;
                    CH_PLUS:
                    begin
                        kind = TK_OPERATOR;
                        prec = PREC_ADD;
                        op   = OP_PLUS;
                    end
                    CH_MINUS:
                    begin
                        kind = TK_OPERATOR;
                        prec = PREC_ADD;
                        op   = OP_MINUS;
                    end
                    CH_TIMES:
                    begin
                        kind = TK_OPERATOR;
                        prec = PREC_MUL;
                        op   = OP_TIMES;
                    end
                    CH_DIVIDE:
                    begin
                        kind = TK_OPERATOR;
                        prec = PREC_MUL;
                        op   = OP_DIVIDE;
                    end
                    CH_POWER:
                    begin
                        kind = TK_OPERATOR;
                        prec = PREC_POW;
                        op   = OP_POWER;
                    end
                    default: ;
                endcase
                add_token(kind, prec, 4'd0, op, pos, POSITION_WIDTH'(1));
            end
        end

        if (is_last) begin
            close_pending();
            // nothing left to report, so mark the end with an empty token
            if (step_count == 0)
                add_token(TK_END, PREC_NONE, 4'd0, OP_PLUS, pos, '0);
            step_tok[step_count-1].eoe = 1'b1;
            clear_scan();
        end
        else
            char_pos = sat_inc(char_pos);

        if (step_count > 0) begin
            step_tok[step_count-1].lor = 1'b1;
            for (int i = 0; i < step_count; i++)
                expected_tokens.insert(expected_tokens.size(), step_tok[i]);
        end
    endtask

    task automatic compare_token(input token_t want);
        if (token_kind !== want.kind)
            report_mismatch("token_kind", token_kind, want.kind);
        if (precedence !== want.prec)
            report_mismatch("precedence", precedence, want.prec);
        if (function_id !== want.fid)
            report_mismatch("function_id", function_id, want.fid);
        if (operator_code !== want.op)
            report_mismatch("operator_code", operator_code, want.op);
        if (token_start !== want.start)
            report_mismatch("token_start", token_start, want.start);
        if (token_length !== want.size)
            report_mismatch("token_length", token_length, want.size);
        if (last_of_run !== want.lor)
            report_mismatch("last_of_run", last_of_run, want.lor);
        if (end_of_expression !== want.eoe)
            report_mismatch("end_of_expression", end_of_expression, want.eoe);
    endtask

    initial
    begin
        fail_count     = 0;
        tokens_checked = 0;
        open_tokens    = 0;
        kinds_seen     = '0;
        clear_scan();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clear_scan();
            expected_tokens.delete();
            open_tokens <= 0;
        end
        else begin
            // the request side goes first: a token leaving now belongs to an older request
            if (in_valid && !in_stall)
                scan_char(char_code, last_char);
            if (out_valid && !out_stall) begin
                if (expected_tokens.size() == 0)
                    report_mismatch("token with none expected, kind", token_kind, 0);
                else begin
                    compare_token(expected_tokens.pop_front());
                    tokens_checked++;
                    if (token_kind <= TK_END)
                        kinds_seen[token_kind] = 1'b1;
                end
            end
            open_tokens <= expected_tokens.size();
        end
    end

endmodule

FILE: test/tb_top.sv
// testbench top for the expression token scanner: reset, stimulus, idling and verdict
module tb_top;
    import ets_pkg::*;

    localparam int PW           = 16;
    localparam int NK           = 4;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_CHARS = 1560;
    localparam int LONG_RUN     = 200;
    localparam int DRAIN_CYCLES = 20;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_stall;
    logic [7:0]    char_code = '0;
    logic          last_char = 1'b0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [3:0]    token_kind;
    logic [1:0]    precedence;
    logic [3:0]    function_id;
    logic [2:0]    operator_code;
    logic [PW-1:0] token_start;
    logic [PW-1:0] token_length;
    logic          last_of_run;
    logic          end_of_expression;

    int            fail_count;
    int            open_tokens;
    int            tokens_checked;
    logic [8:0]    kinds_seen;

    int            send_idle   = 0;
    int            recv_idle   = 0;
    int unsigned   chars_sent  = 0;
    int unsigned   exprs_sent  = 0;
    int unsigned   cycle_count = 0;
    bit            noise_on    = 1'b0;
    logic [7:0]    expr_q[$];

    always #1 clk = ~clk;

    expression_token_scanner_core #(
        .POSITION_WIDTH(PW),
        .NAME_KEEP     (NK)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_code        (char_code),
        .last_char        (last_char),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .token_kind       (token_kind),
        .precedence       (precedence),
        .function_id      (function_id),
        .operator_code    (operator_code),
        .token_start      (token_start),
        .token_length     (token_length),
        .last_of_run      (last_of_run),
        .end_of_expression(end_of_expression)
    );

    ets_token_checker #(
        .POSITION_WIDTH(PW),
        .NAME_KEEP     (NK)
    ) u_token_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_code        (char_code),
        .last_char        (last_char),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .token_kind       (token_kind),
        .precedence       (precedence),
        .function_id      (function_id),
        .operator_code    (operator_code),
        .token_start      (token_start),
        .token_length     (token_length),
        .last_of_run      (last_of_run),
        .end_of_expression(end_of_expression),
        .fail_count       (fail_count),
        .open_tokens      (open_tokens),
        .tokens_checked   (tokens_checked),
        .kinds_seen       (kinds_seen)
    );

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still expected",
                     cycle_count, open_tokens);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- expression building ----------------

    function automatic void add_char(input logic [7:0] c);
        expr_q.insert(expr_q.size(), c);
    endfunction

    function automatic string keyword_text(input int i);
        case (i)
            0:       return "sin";
            1:       return "cos";
            2:       return "tg";
            3:       return "ctg";
            4:       return "asin";
            5:       return "acos";
            6:       return "atan";
            7:       return "actg";
            8:       return "log";
            default: return "sqrt";
        endcase
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endfunction

    function automatic void put_letter();
        if ($urandom_range(0, 1))
            add_char(8'($urandom_range(CH_LO_A, CH_LO_Z)));
        else
            add_char(8'($urandom_range(CH_UP_A, CH_UP_Z)));
    endfunction

    function automatic void put_blank();
        case ($urandom_range(0, 9))
            0: add_char(CH_SPACE);
            1: add_char(8'($urandom_range(CH_TAB, CH_CR)));
            2:
            begin
                add_char(CH_SPACE);
                add_char(CH_SPACE);
            end
            default: ;
        endcase
        if (noise_on && $urandom_range(0, 5) == 0)
            add_char(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_number();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                add_char(CH_DOT);
            else
                add_char(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
    endfunction

    function automatic void put_name(input bit as_call);
        string s;
        int    n;
        bit    upper;
        if (as_call || $urandom_range(0, 2) == 0) begin
            s     = keyword_text($urandom_range(0, 9));
            upper = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < s.len(); i++)
                add_char((upper && i == 0) ? s[i] - 8'h20 : s[i]);
            // an extra letter turns a function into a variable
            if ($urandom_range(0, 7) == 0)
                put_letter();
        end
        else begin
            n = $urandom_range(1, 7);
            for (int i = 0; i < n; i++)
                put_letter();
        end
    endfunction

    function automatic void put_operator();
        case ($urandom_range(0, 4))
            0:       add_char(CH_PLUS);
            1:       add_char(CH_MINUS);
            2:       add_char(CH_TIMES);
            3:       add_char(CH_DIVIDE);
            default: add_char(CH_POWER);
        endcase
    endfunction

    function automatic void put_operand(input int depth);
        int pick;
        pick = $urandom_range(0, (depth >= 2) ? 2 : 4);
        if ($urandom_range(0, 5) == 0)
            add_char(CH_MINUS);
        case (pick)
            0, 1: put_number();
            2:    put_name(1'b0);
            3:
            begin
                put_name(1'b1);
                put_blank();
                add_char(CH_LPAREN);
                put_expr(depth + 1);
                if ($urandom_range(0, 3) == 0) begin
                    add_char(CH_COMMA);
                    put_blank();
                    put_expr(depth + 1);
                end
                add_char(CH_RPAREN);
            end
            default:
            begin
                add_char(CH_LPAREN);
                put_expr(depth + 1);
                add_char(CH_RPAREN);
            end
        endcase
        put_blank();
    endfunction

    function automatic void put_expr(input int depth);
        int terms;
        terms = $urandom_range(1, (depth == 0) ? 4 : 2);
        for (int i = 0; i < terms; i++) begin
            if (i > 0) begin
                put_blank();
                put_operator();
                put_blank();
            end
            put_operand(depth);
        end
    endfunction

    function automatic void build_expr();
        int n;
        noise_on = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 19))
            0:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    add_char(8'($urandom_range(0, 255)));
            end
            1:
            begin
                put_blank();
                add_char(CH_SPACE);
            end
            default:
            begin
                put_blank();
                put_expr(0);
            end
        endcase
    endfunction

    // ---------------- request driving ----------------

    task automatic send_char(input logic [7:0] c, input logic is_last);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_q.size(); i++)
            send_char(expr_q[i], i == expr_q.size() - 1);
        exprs_sent++;
        expr_q.delete();
    endtask

    // hold off requests until every token has come back
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (open_tokens != 0);
    endtask

    initial
    begin
        int unsigned phase_goal;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 18;
        recv_idle = 45;

        // lone blank ending the expression gives the empty end marker
        put_text(" ");
        send_expr();
        // second dot splits a number, mixed-case name, parentheses and two operators
        put_text("(0.9.*Zz)^");
        send_expr();
        put_text("a,1/");
        add_char(8'h00);
        add_char(8'h80);
        add_char(8'hFF);
        add_char(CH_TAB);
        add_char(CH_CR);
        // pending name flushed by a final operator: two tokens on the last character
        put_text("b+");
        send_expr();
        put_text("tg");
        send_expr();
        put_text("7 ");
        send_expr();
        put_text("9");
        send_expr();
        wait_quiet();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0:
                begin
                    send_idle = 18;
                    recv_idle = 45;
                end
                1:
                begin
                    send_idle = 45;
                    recv_idle = 18;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            phase_goal = chars_sent + RANDOM_CHARS / 3;
            while (chars_sent < phase_goal) begin
                build_expr();
                send_expr();
                if ($urandom_range(0, 49) == 0)
                    wait_quiet();
            end
            wait_quiet();
        end

        // one long expression: a long number, then ")A-" and a random name
        add_char(8'($urandom_range(CH_ZERO, CH_NINE)));
        add_char(CH_DOT);
        for (int i = 0; i < LONG_RUN; i++)
            add_char(8'($urandom_range(CH_ZERO, CH_NINE)));
        put_text(")A-");
        put_name(1'b0);
        send_expr();
        // positions restart after the end of an expression
        put_text("x+1");
        send_expr();

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d characters in %0d expressions, %0d tokens compared",
                 chars_sent, exprs_sent, tokens_checked);
        $display("token kinds seen (bit 0 unknown up to bit 8 end marker): %b", kinds_seen);
        if (fail_count == 0 && open_tokens == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
